FILE: rtl/core/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STAMP_BITS = 32;
  localparam int TALLY_BITS = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_WIN = 2'd3;

  // configuration reset values
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] CLICK_MAX_RST  = 16'd400;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [CFG_BITS-1:0] TRIPLE_WIN_RST = 16'd1500;

  localparam logic [TALLY_BITS-1:0] TRIPLE_CLICKS = 8'd3;
  localparam logic [TALLY_BITS-1:0] TALLY_MAX     = 8'd255;

  // pin levels (active low button)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] click_max_ms;
    logic [CFG_BITS-1:0] hold_limit_ms;
    logic [CFG_BITS-1:0] triple_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_BITS-1:0] now_ms;
    logic                  raw_level;
  } poll_t;

  typedef struct packed {
    logic                  is_pressed;
    logic                  long_press_pulse;
    logic                  triple_click_pulse;
    logic [STAMP_BITS-1:0] current_press_ms;
    logic [TALLY_BITS-1:0] triple_click_count;
    logic [STAMP_BITS-1:0] triple_span_ms;
  } gesture_t;

endpackage

FILE: rtl/core/bgd_if.sv
// ----------------------------------------------------------------------------
// bgd_if
// Valid/ready channels for poll beats in and gesture beats out.
// ----------------------------------------------------------------------------
interface bgd_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        raw_level;

  modport source (output valid, output now_ms, output raw_level, input ready);
  modport sink   (input valid, input now_ms, input raw_level, output ready);
endinterface

interface bgd_gesture_if;
  logic        valid;
  logic        ready;
  logic        is_pressed;
  logic        long_press_pulse;
  logic        triple_click_pulse;
  logic [31:0] current_press_ms;
  logic [7:0]  triple_click_count;
  logic [31:0] triple_span_ms;

  modport source (output valid, output is_pressed, output long_press_pulse,
                  output triple_click_pulse, output current_press_ms,
                  output triple_click_count, output triple_span_ms, input ready);
  modport sink   (input valid, input is_pressed, input long_press_pulse,
                  input triple_click_pulse, input current_press_ms,
                  input triple_click_count, input triple_span_ms, output ready);
endinterface

FILE: rtl/core/bgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Timing configuration registers behind a plain write port.
// ----------------------------------------------------------------------------
module bgd_cfg_regs
  import bgd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DEBOUNCE_RST;
      cfg.click_max_ms     <= CLICK_MAX_RST;
      cfg.hold_limit_ms    <= LONG_PRESS_RST;
      cfg.triple_window_ms <= TRIPLE_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg.debounce_ms      <= cfg_data;
        CFG_CLICK_MAX:  cfg.click_max_ms     <= cfg_data;
        CFG_LONG_PRESS: cfg.hold_limit_ms    <= cfg_data;
        CFG_TRIPLE_WIN: cfg.triple_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bgd_core.sv
// ----------------------------------------------------------------------------
// bgd_core
// Gesture state and the single-pass update for one poll.
// ----------------------------------------------------------------------------
module bgd_core
  import bgd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  cfg_t     cfg,
  input  poll_t    poll,
  output gesture_t result
);

  typedef logic [TIME_BITS-1:0] stamp_t;

  logic                  stable_level;
  logic                  previous_raw;
  stamp_t                raw_change_time;
  logic                  long_press_reported;
  logic [TALLY_BITS-1:0] click_tally;
  stamp_t                sequence_start_time;
  stamp_t                press_begin_time;
  logic                  press_timing_valid;
  logic [TALLY_BITS-1:0] captured_count;
  stamp_t                captured_span;

  logic                  stable_level_next;
  stamp_t                raw_change_time_next;
  logic                  long_press_reported_next;
  logic [TALLY_BITS-1:0] click_tally_next;
  stamp_t                sequence_start_time_next;
  stamp_t                press_begin_time_next;
  logic                  press_timing_valid_next;
  logic [TALLY_BITS-1:0] captured_count_next;
  stamp_t                captured_span_next;

  stamp_t now;
  logic   raw;
  logic   raw_changed;
  stamp_t since_press;
  stamp_t since_change;
  stamp_t seq_start_mid;
  stamp_t since_seq;
  logic   long_hit;
  logic   lp_mid;
  logic [TALLY_BITS-1:0] tally_mid;
  logic   take_level;
  logic   press_edge;
  logic   long_pulse;
  logic   triple_pulse;

  assign now          = TIME_BITS'(poll.now_ms);
  assign raw          = poll.raw_level;
  assign raw_changed  = raw != previous_raw;
  assign since_press  = now - press_begin_time;
  assign since_change = raw_changed ? '0 : (now - raw_change_time);

  // hold test on the level as it stood before this poll
  assign long_hit = (stable_level == LEVEL_PRESSED) && !long_press_reported &&
                    press_timing_valid &&
                    (since_press >= TIME_BITS'(cfg.hold_limit_ms));

  assign lp_mid        = long_press_reported | long_hit;
  assign tally_mid     = long_hit ? '0 : click_tally;
  assign seq_start_mid = long_hit ? '0 : sequence_start_time;
  assign since_seq     = now - seq_start_mid;

  assign take_level = (since_change >= TIME_BITS'(cfg.debounce_ms)) && (raw != stable_level);
  assign press_edge = take_level && (raw == LEVEL_PRESSED);

  always_comb begin
    stable_level_next        = stable_level;
    long_press_reported_next = lp_mid;
    click_tally_next         = tally_mid;
    sequence_start_time_next = seq_start_mid;
    press_begin_time_next    = press_begin_time;
    press_timing_valid_next  = press_timing_valid;
    captured_count_next      = captured_count;
    captured_span_next       = captured_span;
    raw_change_time_next     = raw_changed ? now : raw_change_time;
    long_pulse               = long_hit;
    triple_pulse             = 1'b0;

    if (take_level) begin
      stable_level_next = raw;
      if (raw == LEVEL_PRESSED) begin
        press_begin_time_next    = now;
        press_timing_valid_next  = 1'b1;
        long_press_reported_next = 1'b0;
        if (tally_mid == '0 || since_seq > TIME_BITS'(cfg.triple_window_ms)) begin
          click_tally_next         = TALLY_BITS'(1);
          sequence_start_time_next = now;
        end else if (tally_mid != TALLY_MAX) begin
          click_tally_next = tally_mid + TALLY_BITS'(1);
        end
      end else if (lp_mid) begin
        // release ending a long press: not a click
        long_press_reported_next = 1'b0;
        click_tally_next         = '0;
        sequence_start_time_next = '0;
        press_begin_time_next    = '0;
        press_timing_valid_next  = 1'b0;
      end else if (since_press > TIME_BITS'(cfg.click_max_ms)) begin
        click_tally_next = '0;
      end else begin
        if (tally_mid >= TRIPLE_CLICKS &&
            since_seq <= TIME_BITS'(cfg.triple_window_ms)) begin
          captured_count_next      = tally_mid;
          captured_span_next       = since_seq;
          triple_pulse             = 1'b1;
          click_tally_next         = '0;
          sequence_start_time_next = '0;
        end
        press_begin_time_next   = '0;
        press_timing_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level        <= LEVEL_RELEASED;
      previous_raw        <= LEVEL_RELEASED;
      raw_change_time     <= '0;
      long_press_reported <= 1'b0;
      click_tally         <= '0;
      sequence_start_time <= '0;
      press_begin_time    <= '0;
      press_timing_valid  <= 1'b0;
      captured_count      <= '0;
      captured_span       <= '0;
    end else if (en) begin
      stable_level        <= stable_level_next;
      previous_raw        <= raw;
      raw_change_time     <= raw_change_time_next;
      long_press_reported <= long_press_reported_next;
      click_tally         <= click_tally_next;
      sequence_start_time <= sequence_start_time_next;
      press_begin_time    <= press_begin_time_next;
      press_timing_valid  <= press_timing_valid_next;
      captured_count      <= captured_count_next;
      captured_span       <= captured_span_next;
    end
  end

  always_comb begin
    result.is_pressed         = stable_level_next == LEVEL_PRESSED;
    result.long_press_pulse   = long_pulse;
    result.triple_click_pulse = triple_pulse;
    // a fresh press edge reads zero
    result.current_press_ms   = (stable_level_next == LEVEL_PRESSED &&
                                 press_timing_valid_next && !press_edge) ?
                                STAMP_BITS'(since_press) : '0;
    result.triple_click_count = captured_count_next;
    result.triple_span_ms     = STAMP_BITS'(captured_span_next);
  end

endmodule

FILE: rtl/core/button_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Debounce, long-press and triple-click detection for an active-low button.
// ----------------------------------------------------------------------------
// Each poll beat carries a millisecond timestamp and the raw pin level and
// yields exactly one gesture beat: the debounced pressed state, one-beat
// long-press and triple-click pulses, the running press duration and the
// count and span of the last triple click. The block takes one poll per
// cycle while the gesture output is not stalled; an accepted poll is held
// in the poll register, and its result is computed from there and written
// to the gesture register, from which the gesture beat is offered. While
// the gesture register holds a stalled beat, the poll register still takes
// one more poll; after that the input waits for the output to drain. Time
// arithmetic is TIME_BITS wide and wraps; the 32-bit timestamp is truncated
// or zero-extended to it. Write the four timing registers only while idle.
// ----------------------------------------------------------------------------
module button_gesture_detector_top
  import bgd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  bgd_poll_if.sink             poll,
  bgd_gesture_if.source        gesture
);

  cfg_t     cfg;
  poll_t    poll_q;
  logic     poll_vld;
  gesture_t result;
  gesture_t gesture_q;
  logic     gesture_vld;
  logic     advance;

  bgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held poll when the gesture register is free or draining
  assign advance    = poll_vld && (!gesture_vld || gesture.ready);
  assign poll.ready = !poll_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_vld <= 1'b0;
    end else if (poll.ready) begin
      poll_vld <= poll.valid;
    end
  end

  // hold the poll payload until it advances
  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_q.now_ms    <= poll.now_ms;
      poll_q.raw_level <= poll.raw_level;
    end
  end

  bgd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .cfg    (cfg),
    .poll   (poll_q),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_vld <= 1'b0;
    end else if (advance) begin
      gesture_vld <= 1'b1;
    end else if (gesture.ready) begin
      gesture_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_q <= result;
    end
  end

  assign gesture.valid              = gesture_vld;
  assign gesture.is_pressed         = gesture_q.is_pressed;
  assign gesture.long_press_pulse   = gesture_q.long_press_pulse;
  assign gesture.triple_click_pulse = gesture_q.triple_click_pulse;
  assign gesture.current_press_ms   = gesture_q.current_press_ms;
  assign gesture.triple_click_count = gesture_q.triple_click_count;
  assign gesture.triple_span_ms     = gesture_q.triple_span_ms;

endmodule

FILE: rtl/core/bgd_checker.sv
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks on the gesture beats of the detector.
// ----------------------------------------------------------------------------
module bgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_pressed,
  input logic        long_press_pulse,
  input logic        triple_click_pulse,
  input logic [31:0] current_press_ms,
  input logic [7:0]  triple_click_count
);

  // a stalled beat stays valid and holds its triple-click pulse and press time
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(triple_click_pulse) &&
                                $stable(current_press_ms))
    else $error("gesture beat changed while stalled");

  // nothing leaves in the cycle after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("gesture beat right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_pressed |-> current_press_ms == 32'd0)
    else $error("press time while released");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && triple_click_pulse |-> !is_pressed && !long_press_pulse &&
                                        triple_click_count >= 8'd3)
    else $error("bad triple-click beat");

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (gesture.valid),
  .out_ready          (gesture.ready),
  .is_pressed         (gesture.is_pressed),
  .long_press_pulse   (gesture.long_press_pulse),
  .triple_click_pulse (gesture.triple_click_pulse),
  .current_press_ms   (gesture.current_press_ms),
  .triple_click_count (gesture.triple_click_count)
);
